>>> rtl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants of the button debouncer with long-press detection.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

   localparam int DefaultTimeBits = 48;
   localparam int SampleTimeBits  = 48;
   localparam int ButtonIdBits    = 3;
   localparam int DurationBits    = 16;
   localparam int CsrAddrBits     = 3;
   localparam int CsrDataBits     = 32;

   typedef logic [0:0] reg_index_type;

   localparam reg_index_type REG_DEBOUNCE_TIME   = 1'b0;
   localparam reg_index_type REG_LONG_PRESS_TIME = 1'b1;

   localparam logic [DurationBits-1:0] DEBOUNCE_TIME_RESET   = 16'd30;
   localparam logic [DurationBits-1:0] LONG_PRESS_TIME_RESET = 16'd800;

   localparam logic GESTURE_SHORT = 1'b0;
   localparam logic GESTURE_LONG  = 1'b1;

   typedef struct packed {
      logic [DurationBits-1:0] debounce_time;
      logic [DurationBits-1:0] long_press_time;
   } cfg_type;

endpackage

`default_nettype wire

>>> rtl/bdlp_csr.sv
// ----------------------------------------------------------------------------
// bdlp_csr
// Configuration registers behind the register port: debounce and long-press time.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [bdlp_pkg::CsrAddrBits-1:0]    csr_paddr,
   input  wire  [bdlp_pkg::CsrDataBits-1:0]    csr_pwdata,
   output logic [bdlp_pkg::CsrDataBits-1:0]    csr_prdata,
   output logic                                csr_pready,
   output bdlp_pkg::cfg_type                   cfg
);
   import bdlp_pkg::*;

   logic [DurationBits-1:0] debounce_time_ff;
   logic [DurationBits-1:0] debounce_time_in;
   logic [DurationBits-1:0] long_press_time_ff;
   logic [DurationBits-1:0] long_press_time_in;
   reg_index_type           index;
   logic                    write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      debounce_time_in   = debounce_time_ff;
      long_press_time_in = long_press_time_ff;
      csr_prdata         = '0;
      unique case (index)
         REG_DEBOUNCE_TIME: begin
            if (write_en) begin
               debounce_time_in = csr_pwdata[DurationBits-1:0];
            end
            csr_prdata = {{(CsrDataBits-DurationBits){1'b0}}, debounce_time_ff};
         end
         REG_LONG_PRESS_TIME: begin
            if (write_en) begin
               long_press_time_in = csr_pwdata[DurationBits-1:0];
            end
            csr_prdata = {{(CsrDataBits-DurationBits){1'b0}}, long_press_time_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff   <= DEBOUNCE_TIME_RESET;
         long_press_time_ff <= LONG_PRESS_TIME_RESET;
      end else begin
         debounce_time_ff   <= debounce_time_in;
         long_press_time_ff <= long_press_time_in;
      end
   end

   assign cfg.debounce_time   = debounce_time_ff;
   assign cfg.long_press_time = long_press_time_ff;

endmodule

`default_nettype wire

>>> rtl/bdlp_core.sv
// ----------------------------------------------------------------------------
// bdlp_core
// Debounce state and event decision for one registered sample per cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_core #(
   parameter int TIME_BITS = bdlp_pkg::DefaultTimeBits
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  bdlp_pkg::cfg_type                    cfg,
   input  wire                                  step,
   input  wire                                  raw_level,
   input  wire  [TIME_BITS-1:0]                 now,
   output logic                                 emit,
   output logic                                 gesture
);
   import bdlp_pkg::*;

   function automatic logic elapsed(input logic [TIME_BITS-1:0] t_now,
                                    input logic [TIME_BITS-1:0] t_since,
                                    input logic [DurationBits-1:0] dur);
      logic [TIME_BITS-1:0] diff;
      diff    = t_now - t_since;
      elapsed = (t_now >= t_since) &&
                (diff >= {{(TIME_BITS-DurationBits){1'b0}}, dur});
   endfunction

   logic                 seeded_ff, seeded_in;
   logic                 candidate_level_ff, candidate_level_in;
   logic                 stable_level_ff, stable_level_in;
   logic                 long_sent_ff, long_sent_in;
   logic [TIME_BITS-1:0] candidate_start_ff, candidate_start_in;
   logic [TIME_BITS-1:0] press_start_ff, press_start_in;

   logic                 debounce_ok;
   logic                 confirm;
   logic                 press_confirm;
   logic                 long_sent_mid;
   logic                 long_ok;
   logic                 short_emit;
   logic                 long_emit;

   always_comb begin
      candidate_start_in = (raw_level != candidate_level_ff) ? now : candidate_start_ff;
      debounce_ok        = elapsed(now, candidate_start_in, cfg.debounce_time);
      confirm            = (raw_level != stable_level_ff) && debounce_ok;
      press_confirm      = confirm && raw_level;
      long_sent_mid      = confirm ? 1'b0 : long_sent_ff;
      long_ok            = press_confirm ?
                           elapsed(now, candidate_start_in, cfg.long_press_time) :
                           elapsed(now, press_start_ff, cfg.long_press_time);
      stable_level_in    = confirm ? raw_level : stable_level_ff;
      press_start_in     = press_confirm ? candidate_start_in : press_start_ff;
      short_emit         = confirm && !raw_level && !long_sent_ff;
      long_emit          = stable_level_in && raw_level && !long_sent_mid && long_ok;
      long_sent_in       = long_emit ? 1'b1 : long_sent_mid;
      candidate_level_in = raw_level;
      seeded_in          = 1'b1;
      emit               = 1'b0;
      gesture            = GESTURE_SHORT;
      if (!seeded_ff) begin
         stable_level_in    = raw_level;
         candidate_start_in = now;
         press_start_in     = now;
         long_sent_in       = 1'b0;
      end else if (short_emit) begin
         emit    = 1'b1;
         gesture = GESTURE_SHORT;
      end else if (long_emit) begin
         emit    = 1'b1;
         gesture = GESTURE_LONG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff          <= 1'b0;
         candidate_level_ff <= 1'b0;
         stable_level_ff    <= 1'b0;
         long_sent_ff       <= 1'b0;
         candidate_start_ff <= '0;
         press_start_ff     <= '0;
      end else if (step) begin
         seeded_ff          <= seeded_in;
         candidate_level_ff <= candidate_level_in;
         stable_level_ff    <= stable_level_in;
         long_sent_ff       <= long_sent_in;
         candidate_start_ff <= candidate_start_in;
         press_start_ff     <= press_start_in;
      end
   end

   // seeding sample never produces an event
   assert property (@(posedge clock) disable iff (reset)
      (step && !seeded_ff) |-> !emit)
      else $error("event on seeding sample");

   // a long press is remembered until release
   assert property (@(posedge clock) disable iff (reset)
      (step && emit && gesture == GESTURE_LONG) |=> long_sent_ff)
      else $error("long press not recorded");

   // state only moves on a sample
   assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(stable_level_ff) && $stable(long_sent_ff)))
      else $error("state changed without sample");

   // no second long press while one is pending release
   assert property (@(posedge clock) disable iff (reset)
      (step && long_sent_ff && stable_level_ff && !confirm) |-> !emit)
      else $error("repeated long press");

endmodule

`default_nettype wire

>>> rtl/button_debounce_long_press.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Button debouncer emitting short-press and long-press events from timestamped samples.
// ----------------------------------------------------------------------------
// Each sample transfer is registered in the input register, processed against the
// debounce state once the event register is free or being drained, and any event
// lands in an output register; a new sample is taken every cycle as long as the
// event register is free or being drained, so the throughput is one sample per clock.
// The first sample after reset only seeds the state. Timestamps are kept TIME_BITS
// wide and must not decrease; an interval whose start lies after the current time
// counts as not elapsed. Registers: debounce_time at byte 0, long_press_time at byte 4.
`default_nettype none

module button_debounce_long_press #(
   parameter int TIME_BITS = bdlp_pkg::DefaultTimeBits
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [bdlp_pkg::ButtonIdBits-1:0]     req_button_id,
   input  wire                                   req_raw_level,
   input  wire  [bdlp_pkg::SampleTimeBits-1:0]   req_sample_time,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [bdlp_pkg::ButtonIdBits-1:0]     rsp_event_button,
   output logic                                  rsp_gesture,
   output logic [bdlp_pkg::SampleTimeBits-1:0]   rsp_event_time,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [bdlp_pkg::CsrAddrBits-1:0]      csr_paddr,
   input  wire  [bdlp_pkg::CsrDataBits-1:0]      csr_pwdata,
   output logic [bdlp_pkg::CsrDataBits-1:0]      csr_prdata,
   output logic                                  csr_pready
);
   import bdlp_pkg::*;

   cfg_type                   cfg;

   logic                      in_valid_ff;
   logic [ButtonIdBits-1:0]   in_button_ff;
   logic                      in_raw_ff;
   logic [SampleTimeBits-1:0] in_time_ff;

   logic                      out_valid_ff;
   logic [ButtonIdBits-1:0]   out_button_ff;
   logic                      out_gesture_ff;
   logic [SampleTimeBits-1:0] out_time_ff;

   logic                      advance;
   logic                      step;
   logic                      emit;
   logic                      gesture;
   logic [TIME_BITS-1:0]      now;
   logic [SampleTimeBits-1:0] event_time;

   generate
      if (TIME_BITS >= SampleTimeBits) begin : g_wide
         assign now        = {{(TIME_BITS-SampleTimeBits){1'b0}}, in_time_ff};
         assign event_time = in_time_ff;
      end else begin : g_narrow
         assign now        = in_time_ff[TIME_BITS-1:0];
         assign event_time = {{(SampleTimeBits-TIME_BITS){1'b0}}, now};
      end
   endgenerate

   assign advance   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   bdlp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bdlp_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .raw_level (in_raw_ff),
      .now       (now),
      .emit      (emit),
      .gesture   (gesture)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_button_ff <= req_button_id;
         in_raw_ff    <= req_raw_level;
         in_time_ff   <= req_sample_time;
      end
   end

   // event register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         out_button_ff  <= in_button_ff;
         out_gesture_ff <= gesture;
         out_time_ff    <= event_time;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_button = out_button_ff;
   assign rsp_gesture      = out_gesture_ff;
   assign rsp_event_time   = out_time_ff;

endmodule

`default_nettype wire
